@@ sv/bda_pkg.sv @@
// shared types and constants of the banker's safety check block
package bda_pkg;

  // unit counts, field and index widths
  localparam int AMT_W      = 8;
  localparam int IDX_W      = 4;
  localparam int FIELD_RES  = 3;
  localparam int OUT_MAX    = 8;
  localparam int PROC_OUT_W = 3;

  // request kinds
  typedef enum logic [1:0] {
    REQ_LOAD_AVAIL = 2'd0,
    REQ_LOAD_ROW   = 2'd1,
    REQ_REQUEST    = 2'd2,
    REQ_UNUSED     = 2'd3
  } req_type_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_EXCEEDS  = 3'd1,
    ST_WAIT     = 3'd2,
    ST_UNSAFE   = 3'd3,
    ST_LOAD_OK  = 3'd4,
    ST_LOAD_REJ = 3'd5
  } status_e;

  // operations the sequencer issues to every resource lane
  typedef enum logic [2:0] {
    LOP_NONE,
    LOP_LOAD_AVAIL,
    LOP_LOAD_ROW,
    LOP_WORK_INIT,
    LOP_WORK_ADD,
    LOP_COMMIT
  } lane_op_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_COMMIT,
    S_SEQ,
    S_RESULT
  } ctrl_state_e;

  // command to the lanes: operation, row index and requesting process
  typedef struct packed {
    lane_op_e          op;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  pid;
  } lane_cmd_t;

  // per-lane findings
  typedef struct packed {
    logic exceed;
    logic no_room;
    logic claim_low;
    logic fits;
  } lane_stat_t;

endpackage

@@ sv/bda_req_if.sv @@
// request channel: valid/ready handshake with the request item
interface bda_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [2:0] process_id;
  logic [7:0] amount_0;
  logic [7:0] amount_1;
  logic [7:0] amount_2;
  logic [7:0] claim_0;
  logic [7:0] claim_1;
  logic [7:0] claim_2;

  modport source (
    output valid, req_type, process_id, amount_0, amount_1, amount_2,
           claim_0, claim_1, claim_2,
    input  ready
  );

  modport sink (
    input  valid, req_type, process_id, amount_0, amount_1, amount_2,
           claim_0, claim_1, claim_2,
    output ready
  );
endinterface

@@ sv/bda_rsp_if.sv @@
// response channel: valid/ready handshake with the result item
interface bda_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] process_in_order;
  logic       last;

  modport source (
    output valid, status, process_in_order, last,
    input  ready
  );

  modport sink (
    input  valid, status, process_in_order, last,
    output ready
  );
endinterface

@@ sv/bda_lane.sv @@
// one resource lane: available count, allocation and need rows, work counter
module bda_lane #(
  parameter int PROCESSES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bda_pkg::lane_cmd_t    cmd_i,
  input  logic [7:0]            amount_i,
  input  logic [7:0]            claim_i,
  output bda_pkg::lane_stat_t   stat_o
);
  import bda_pkg::*;

  localparam int PW     = $clog2(PROCESSES);
  localparam int WORK_W = AMT_W + $clog2(PROCESSES + 1);

  logic [AMT_W-1:0]  avail_q;
  logic [AMT_W-1:0]  alloc_q [PROCESSES];
  logic [AMT_W-1:0]  need_q  [PROCESSES];
  logic [WORK_W-1:0] work_q;

  logic [PW-1:0]     idx;
  logic              own;
  logic [AMT_W-1:0]  alloc_rd;
  logic [AMT_W-1:0]  need_rd;
  logic [AMT_W-1:0]  alloc_eff;
  logic [AMT_W-1:0]  need_eff;

  // row read, with the pending request applied to the requesting row
  assign idx       = cmd_i.idx[PW-1:0];
  assign own       = (idx == cmd_i.pid[PW-1:0]);
  assign alloc_rd  = alloc_q[idx];
  assign need_rd   = need_q[idx];
  assign alloc_eff = own ? AMT_W'(alloc_rd + amount_i) : alloc_rd;
  assign need_eff  = own ? AMT_W'(need_rd - amount_i) : need_rd;

  // lane findings
  assign stat_o.exceed    = (amount_i > need_rd);
  assign stat_o.no_room   = (amount_i > avail_q);
  assign stat_o.claim_low = (claim_i < amount_i);
  assign stat_o.fits      = (WORK_W'(need_eff) <= work_q);

  // table updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_q <= '0;
      for (int p = 0; p < PROCESSES; p++) begin
        alloc_q[p] <= '0;
        need_q[p]  <= '0;
      end
    end else begin
      unique case (cmd_i.op)
        LOP_LOAD_AVAIL: begin
          avail_q <= amount_i;
        end
        LOP_LOAD_ROW: begin
          alloc_q[idx] <= amount_i;
          need_q[idx]  <= AMT_W'(claim_i - amount_i);
        end
        LOP_COMMIT: begin
          avail_q      <= AMT_W'(avail_q - amount_i);
          alloc_q[idx] <= AMT_W'(alloc_rd + amount_i);
          need_q[idx]  <= AMT_W'(need_rd - amount_i);
        end
        default: begin
        end
      endcase
    end
  end

  // work vector of the safety check
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      LOP_WORK_INIT: work_q <= WORK_W'(AMT_W'(avail_q - amount_i));
      LOP_WORK_ADD:  work_q <= WORK_W'(work_q + WORK_W'(alloc_eff));
      default:       work_q <= work_q;
    endcase
  end

endmodule

@@ sv/bda_ctrl.sv @@
// sequencer: decodes items, merges lane findings, runs the scan, emits results
module bda_ctrl #(
  parameter int PROCESSES = 8,
  parameter int RESOURCES = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [2:0]           pid_i,
  input  bda_pkg::lane_stat_t  stat_i [RESOURCES],
  output bda_pkg::lane_cmd_t   cmd_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [2:0]           proc_o,
  output logic                 last_o
);
  import bda_pkg::*;

  localparam int PW     = $clog2(PROCESSES);
  localparam int CW     = $clog2(PROCESSES + 1);
  localparam int EMIT_N = (PROCESSES < OUT_MAX) ? PROCESSES : OUT_MAX;
  localparam int EW     = $clog2(EMIT_N);

  ctrl_state_e             state_q, state_d;
  logic [PW-1:0]           ptr_q, ptr_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    prog_q, prog_d;
  logic [PROCESSES-1:0]    done_q, done_d;
  logic [EW-1:0]           emit_q, emit_d;
  status_e                 res_q, res_d;
  logic [PW-1:0]           seq_q [PROCESSES];
  logic                    seq_we;

  logic                    out_valid_q;
  status_e                 out_status_q;
  logic [PROC_OUT_W-1:0]   out_proc_q;
  logic                    out_last_q;

  logic                    all_fit;
  logic                    any_claim_low;
  logic                    fail_found;
  logic                    fail_exceed;
  logic                    pid_oor;
  logic                    hit;
  logic [CW-1:0]           cnt_nx;
  logic                    slot_free;
  logic                    push;
  status_e                 push_status;
  logic [PROC_OUT_W-1:0]   push_proc;
  logic                    push_last;

  // merge of the lane findings, first failing resource decides
  always_comb begin
    all_fit       = 1'b1;
    any_claim_low = 1'b0;
    fail_found    = 1'b0;
    fail_exceed   = 1'b0;
    for (int r = 0; r < RESOURCES; r++) begin
      all_fit       = all_fit & stat_i[r].fits;
      any_claim_low = any_claim_low | stat_i[r].claim_low;
      if (!fail_found && (stat_i[r].exceed || stat_i[r].no_room)) begin
        fail_found  = 1'b1;
        fail_exceed = stat_i[r].exceed;
      end
    end
  end

  assign pid_oor    = (int'(pid_i) >= PROCESSES);
  assign hit        = !done_q[ptr_q] && all_fit;
  assign cnt_nx     = CW'(cnt_q + CW'(hit));
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // next state and lane commands
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    prog_d      = prog_q;
    done_d      = done_q;
    emit_d      = emit_q;
    res_d       = res_q;
    seq_we      = 1'b0;
    push        = 1'b0;
    push_status = res_q;
    push_proc   = '0;
    push_last   = 1'b1;
    cmd_o.op    = LOP_NONE;
    cmd_o.idx   = IDX_W'(pid_i);
    cmd_o.pid   = IDX_W'(pid_i);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_RESULT;
        unique case (req_type_e'(req_type_i))
          REQ_LOAD_AVAIL: begin
            cmd_o.op = LOP_LOAD_AVAIL;
            res_d    = ST_LOAD_OK;
          end
          REQ_LOAD_ROW: begin
            if (pid_oor || any_claim_low) begin
              res_d = ST_LOAD_REJ;
            end else begin
              cmd_o.op = LOP_LOAD_ROW;
              res_d    = ST_LOAD_OK;
            end
          end
          REQ_REQUEST: begin
            if (pid_oor) begin
              res_d = ST_EXCEEDS;
            end else if (fail_found) begin
              res_d = fail_exceed ? ST_EXCEEDS : ST_WAIT;
            end else begin
              cmd_o.op = LOP_WORK_INIT;
              ptr_d    = '0;
              cnt_d    = '0;
              prog_d   = 1'b0;
              done_d   = '0;
              state_d  = S_SCAN;
            end
          end
          REQ_UNUSED: begin
            res_d = ST_LOAD_REJ;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.idx = IDX_W'(ptr_q);
        if (hit) begin
          cmd_o.op      = LOP_WORK_ADD;
          done_d[ptr_q] = 1'b1;
          seq_we        = 1'b1;
          cnt_d         = cnt_nx;
          prog_d        = 1'b1;
        end
        if (cnt_nx == CW'(PROCESSES)) begin
          state_d = S_COMMIT;
        end else if (ptr_q == PW'(PROCESSES - 1)) begin
          if (prog_q || hit) begin
            ptr_d  = '0;
            prog_d = 1'b0;
          end else begin
            res_d   = ST_UNSAFE;
            state_d = S_RESULT;
          end
        end else begin
          ptr_d = PW'(ptr_q + 1'b1);
        end
      end
      S_COMMIT: begin
        cmd_o.op = LOP_COMMIT;
        emit_d   = '0;
        state_d  = S_SEQ;
      end
      S_SEQ: begin
        push_status = ST_GRANTED;
        push_proc   = PROC_OUT_W'(seq_q[PW'(emit_q)]);
        push_last   = (emit_q == EW'(EMIT_N - 1));
        if (slot_free) begin
          push = 1'b1;
          if (push_last) begin
            state_d = S_IDLE;
          end else begin
            emit_d = EW'(emit_q + 1'b1);
          end
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      cnt_q   <= '0;
      prog_q  <= 1'b0;
      done_q  <= '0;
      emit_q  <= '0;
      res_q   <= ST_LOAD_OK;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      prog_q  <= prog_d;
      done_q  <= done_d;
      emit_q  <= emit_d;
      res_q   <= res_d;
    end
  end

  // safe sequence buffer
  always_ff @(posedge clk_i) begin
    if (seq_we) begin
      seq_q[cnt_q[PW-1:0]] <= ptr_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_status_q <= push_status;
      out_proc_q   <= push_proc;
      out_last_q   <= push_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign proc_o      = out_proc_q;
  assign last_o      = out_last_q;

`ifndef SYNTHESIS
  // finished count tracks the done flags throughout the scan
  a_cnt_matches_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ($countones(done_q) == int'(cnt_q)))
    else $error("finished count out of step with done flags");

  // a grant is committed only once every process has finished
  a_commit_all_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |-> (&done_q))
    else $error("commit without a complete safe sequence");

  // the final result of an item returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_last) |=> (state_q == S_IDLE))
    else $error("sequencer not idle after final result");

  // the finished count never passes the number of processes
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= PROCESSES)
    else $error("finished count above process count");
`endif

endmodule

@@ sv/bankers_deadlock_avoidance_top.sv @@
// top level of the banker's algorithm safety check block
// Banker's algorithm resource manager. Each request item is taken only while the block is idle.
// A load of the available vector or of a process row, and any refused request, holds the
// block through the decode state and the result state; the result is registered in the
// output register once the output slot is free. A request that passes the need and
// availability tests runs the safety check: one process row per cycle is read by all
// resource lanes at once through a shared row index, in repeated passes until every process
// finishes or a pass finishes none; then come the commit state and the emission of the
// sequence entries, at most min(PROCESSES, 8). An unsafe request leaves the tables
// unchanged. All tables clear at reset; no clearing pass is needed.
module bankers_deadlock_avoidance_top #(
  parameter int PROCESSES = 8,
  parameter int RESOURCES = 3
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bda_req_if.sink  req_i,
  bda_rsp_if.source rsp_o
);
  import bda_pkg::*;

  logic [1:0]           type_q;
  logic [2:0]           pid_q;
  logic [AMT_W-1:0]     amt_q [FIELD_RES];
  logic [AMT_W-1:0]     clm_q [FIELD_RES];
  logic                 accept;
  logic                 ready;

  lane_cmd_t            cmd;
  lane_stat_t           stat [RESOURCES];
  logic [AMT_W-1:0]     lane_amt [RESOURCES];
  logic [AMT_W-1:0]     lane_clm [RESOURCES];

  assign req_i.ready = ready;
  assign accept      = req_i.valid && ready;

  // item holding registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q   <= req_i.req_type;
      pid_q    <= req_i.process_id;
      amt_q[0] <= req_i.amount_0;
      amt_q[1] <= req_i.amount_1;
      amt_q[2] <= req_i.amount_2;
      clm_q[0] <= req_i.claim_0;
      clm_q[1] <= req_i.claim_1;
      clm_q[2] <= req_i.claim_2;
    end
  end

  // resource lanes, resources past the carried fields read zero
  for (genvar r = 0; r < RESOURCES; r++) begin : g_lane
    if (r < FIELD_RES) begin : g_field
      assign lane_amt[r] = amt_q[r];
      assign lane_clm[r] = clm_q[r];
    end else begin : g_zero
      assign lane_amt[r] = '0;
      assign lane_clm[r] = '0;
    end

    bda_lane #(
      .PROCESSES (PROCESSES)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .amount_i (lane_amt[r]),
      .claim_i  (lane_clm[r]),
      .stat_o   (stat[r])
    );
  end

  // sequencer and merge
  bda_ctrl #(
    .PROCESSES (PROCESSES),
    .RESOURCES (RESOURCES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (ready),
    .req_type_i  (type_q),
    .pid_i       (pid_q),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_o    (rsp_o.status),
    .proc_o      (rsp_o.process_in_order),
    .last_o      (rsp_o.last)
  );

endmodule

@@ verif/bda_grant_checker.sv @@
// checker for the banker's safety check block: predicts results and compares them
`timescale 1ns / 1ps
module bda_grant_checker #(
  parameter int PROCESSES = 8,
  parameter int RESOURCES = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  bda_req_if   req_i,
  bda_rsp_if   rsp_i,
  output int   mismatch_cnt_o,
  output int   pending_cnt_o,
  output int   result_cnt_o,
  output int   grant_cnt_o,
  output int   unsafe_cnt_o
);
  import bda_pkg::*;

  // one accepted request item
  typedef struct packed {
    req_type_e                          kind;
    logic [2:0]                         pid;
    logic [FIELD_RES-1:0][AMT_W-1:0]    amt;
    logic [FIELD_RES-1:0][AMT_W-1:0]    claim;
  } bda_req_t;

  // one result item
  typedef struct packed {
    status_e                 status;
    logic [PROC_OUT_W-1:0]   proc;
    logic                    last;
  } bda_result_t;

  // shadow tables of the block
  logic [AMT_W-1:0] avail_units [RESOURCES];
  logic [AMT_W-1:0] alloc_units [PROCESSES][RESOURCES];
  logic [AMT_W-1:0] need_units  [PROCESSES][RESOURCES];

  bda_result_t outcome_q [$];
  int          safe_order [$];
  int          mismatch_total = 0;
  int          pending_total  = 0;
  int          result_total   = 0;
  int          grant_total    = 0;
  int          unsafe_total   = 0;

  assign mismatch_cnt_o = mismatch_total;
  assign pending_cnt_o  = pending_total;
  assign result_cnt_o   = result_total;
  assign grant_cnt_o    = grant_total;
  assign unsafe_cnt_o   = unsafe_total;

  // resources past the item's fields read as zero
  function automatic int unsigned amount_of(bda_req_t q, int r);
    if (r < FIELD_RES) return q.amt[r];
    return 0;
  endfunction

  function automatic int unsigned claim_of(bda_req_t q, int r);
    if (r < FIELD_RES) return q.claim[r];
    return 0;
  endfunction

  function automatic void push_outcome(status_e st, int unsigned proc, bit last);
    bda_result_t e;
    e.status = st;
    e.proc   = proc[PROC_OUT_W-1:0];
    e.last   = last;
    outcome_q.push_back(e);
  endfunction

  // repeated passes in index order until a pass finishes nobody
  function automatic void find_safe_order();
    int unsigned work [RESOURCES];
    bit          finished [PROCESSES];
    bit          progress;
    bit          fits;
    safe_order.delete();
    for (int r = 0; r < RESOURCES; r++) work[r] = avail_units[r];
    for (int p = 0; p < PROCESSES; p++) finished[p] = 1'b0;
    progress = 1'b1;
    while (progress) begin
      progress = 1'b0;
      for (int p = 0; p < PROCESSES; p++) begin
        if (!finished[p]) begin
          fits = 1'b1;
          for (int r = 0; r < RESOURCES; r++)
            if (need_units[p][r] > work[r]) fits = 1'b0;
          if (fits) begin
            for (int r = 0; r < RESOURCES; r++) work[r] += alloc_units[p][r];
            finished[p] = 1'b1;
            safe_order.push_back(p);
            progress = 1'b1;
          end
        end
      end
    end
  endfunction

  // update the shadow tables and queue the results one item causes
  function automatic void predict_outcome(bda_req_t q);
    status_e verdict;
    bit      claim_low;
    int      emit;
    case (q.kind)
      REQ_LOAD_AVAIL: begin
        for (int r = 0; r < RESOURCES; r++) avail_units[r] = AMT_W'(amount_of(q, r));
        push_outcome(ST_LOAD_OK, 0, 1'b1);
      end
      REQ_LOAD_ROW: begin
        claim_low = 1'b0;
        for (int r = 0; r < RESOURCES; r++)
          if (claim_of(q, r) < amount_of(q, r)) claim_low = 1'b1;
        if (q.pid >= PROCESSES || claim_low) begin
          push_outcome(ST_LOAD_REJ, 0, 1'b1);
        end else begin
          for (int r = 0; r < RESOURCES; r++) begin
            alloc_units[q.pid][r] = AMT_W'(amount_of(q, r));
            need_units[q.pid][r]  = AMT_W'(claim_of(q, r) - amount_of(q, r));
          end
          push_outcome(ST_LOAD_OK, 0, 1'b1);
        end
      end
      REQ_REQUEST: begin
        if (q.pid >= PROCESSES) begin
          push_outcome(ST_EXCEEDS, 0, 1'b1);
        end else begin
          // need before availability, resource by resource
          verdict = ST_GRANTED;
          for (int r = 0; r < RESOURCES && verdict == ST_GRANTED; r++) begin
            if (amount_of(q, r) > need_units[q.pid][r]) verdict = ST_EXCEEDS;
            else if (amount_of(q, r) > avail_units[r]) verdict = ST_WAIT;
          end
          if (verdict != ST_GRANTED) begin
            push_outcome(verdict, 0, 1'b1);
          end else begin
            for (int r = 0; r < RESOURCES; r++) begin
              avail_units[r]        -= AMT_W'(amount_of(q, r));
              alloc_units[q.pid][r] += AMT_W'(amount_of(q, r));
              need_units[q.pid][r]  -= AMT_W'(amount_of(q, r));
            end
            find_safe_order();
            if (safe_order.size() != PROCESSES) begin
              // unsafe: undo the tentative grant
              for (int r = 0; r < RESOURCES; r++) begin
                avail_units[r]        += AMT_W'(amount_of(q, r));
                alloc_units[q.pid][r] -= AMT_W'(amount_of(q, r));
                need_units[q.pid][r]  += AMT_W'(amount_of(q, r));
              end
              push_outcome(ST_UNSAFE, 0, 1'b1);
              unsafe_total++;
            end else begin
              emit = (safe_order.size() < OUT_MAX) ? safe_order.size() : OUT_MAX;
              for (int k = 0; k < emit; k++)
                push_outcome(ST_GRANTED, safe_order[k], k == emit - 1);
              grant_total++;
            end
          end
        end
      end
      default: push_outcome(ST_LOAD_REJ, 0, 1'b1);
    endcase
  endfunction

  function automatic void note_mismatch(string what, bda_result_t want, bda_result_t got);
    mismatch_total++;
    if (mismatch_total <= 10)
      $display("%0t result mismatch (%s): expected status %0d proc %0d last %0d,",
               $time, what, want.status, want.proc, want.last,
               " got status %0d proc %0d last %0d",
               got.status, got.proc, got.last);
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    bda_req_t    q;
    bda_result_t got;
    bda_result_t want;
    if (!rst_ni) begin
      for (int r = 0; r < RESOURCES; r++) avail_units[r] = '0;
      for (int p = 0; p < PROCESSES; p++)
        for (int r = 0; r < RESOURCES; r++) begin
          alloc_units[p][r] = '0;
          need_units[p][r]  = '0;
        end
      outcome_q.delete();
      pending_total = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        q.kind     = req_type_e'(req_i.req_type);
        q.pid      = req_i.process_id;
        q.amt[0]   = req_i.amount_0;
        q.amt[1]   = req_i.amount_1;
        q.amt[2]   = req_i.amount_2;
        q.claim[0] = req_i.claim_0;
        q.claim[1] = req_i.claim_1;
        q.claim[2] = req_i.claim_2;
        predict_outcome(q);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        got.status = status_e'(rsp_i.status);
        got.proc   = rsp_i.process_in_order;
        got.last   = rsp_i.last;
        result_total++;
        if (outcome_q.size() == 0) begin
          note_mismatch("nothing expected", '0, got);
        end else begin
          want = outcome_q.pop_front();
          if (got.status !== want.status) note_mismatch("status", want, got);
          else if (got.proc !== want.proc) note_mismatch("process_in_order", want, got);
          else if (got.last !== want.last) note_mismatch("last", want, got);
        end
      end
      pending_total = outcome_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// testbench top for the banker's safety check block: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb;
  import bda_pkg::*;

  localparam int PROCESSES    = 8;
  localparam int RESOURCES    = 3;
  localparam int RANDOM_ITEMS = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   take_idle_pct;
  int   sent_items;
  int   stall_cycles;
  int   mismatch_cnt;
  int   pending_cnt;
  int   result_cnt;
  int   grant_cnt;
  int   unsafe_cnt;

  bda_req_if req_if ();
  bda_rsp_if rsp_if ();

  bankers_deadlock_avoidance_top #(
    .PROCESSES(PROCESSES),
    .RESOURCES(RESOURCES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  bda_grant_checker #(
    .PROCESSES(PROCESSES),
    .RESOURCES(RESOURCES)
  ) u_grant_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_cnt_o (pending_cnt),
    .result_cnt_o  (result_cnt),
    .grant_cnt_o   (grant_cnt),
    .unsafe_cnt_o  (unsafe_cnt)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result receiver with random stalls
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready = ($urandom_range(0, 99) >= take_idle_pct);
    end
  end

  // watchdog on cycles with no item moving on either channel
  initial stall_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // mostly small unit counts, now and then any byte
  function automatic logic [7:0] pick_units(int small_max);
    if ($urandom_range(0, 99) < 90) return 8'($urandom_range(0, small_max));
    return 8'($urandom_range(0, 255));
  endfunction

  // drive one request item and wait for its acceptance
  task automatic send_req(req_type_e kind, logic [2:0] pid, logic [7:0] a0, logic [7:0] a1,
                          logic [7:0] a2, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.req_type   = kind;
    req_if.process_id = pid;
    req_if.amount_0   = a0;
    req_if.amount_1   = a1;
    req_if.amount_2   = a2;
    req_if.claim_0    = c0;
    req_if.claim_1    = c1;
    req_if.claim_2    = c2;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
    @(negedge clk_i);
    if (kind != REQ_UNUSED) sent_items++;
  endtask

  // hold off until every expected result has come back
  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  // available vector, process rows, then a burst of requests against them
  task automatic run_scenario();
    logic [7:0] alloc [3];
    logic [7:0] claim [3];
    int         bad;
    send_req(REQ_LOAD_AVAIL, 3'($urandom_range(0, 7)), pick_units(24), pick_units(24),
             pick_units(24), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
    for (int p = 0; p < PROCESSES; p++) begin
      if ($urandom_range(0, 99) < 85) begin
        for (int r = 0; r < 3; r++) begin
          alloc[r] = pick_units(8);
          claim[r] = alloc[r] + 8'($urandom_range(0, 12));
        end
        // occasionally a claim below the allocation
        if ($urandom_range(0, 99) < 10) begin
          bad = $urandom_range(0, 2);
          claim[bad] = alloc[bad] - 8'd1;
        end
        send_req(REQ_LOAD_ROW, 3'(p), alloc[0], alloc[1], alloc[2],
                 claim[0], claim[1], claim[2]);
      end
    end
    repeat ($urandom_range(6, 14)) begin
      if ($urandom_range(0, 99) < 5)
        send_req(req_type_e'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else
        send_req(REQ_REQUEST, 3'($urandom_range(0, 7)), pick_units(4), pick_units(4),
                 pick_units(4), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    end
  endtask

  // main sequence
  initial begin
    int random_start;
    int phase;
    int next_phase;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_LOAD_AVAIL;
    req_if.process_id = '0;
    req_if.amount_0   = '0;
    req_if.amount_1   = '0;
    req_if.amount_2   = '0;
    req_if.claim_0    = '0;
    req_if.claim_1    = '0;
    req_if.claim_2    = '0;
    send_idle_pct     = 37;
    take_idle_pct     = 87;
    sent_items        = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero request on the cleared tables: every process finishes at once
    send_req(REQ_REQUEST, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    // unused request kind with every bit set
    send_req(REQ_UNUSED, 3'd7, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_req(REQ_LOAD_AVAIL, 3'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    // full allocation with no need left
    send_req(REQ_LOAD_ROW, 3'd7, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    // claim below allocation on the last resource only
    send_req(REQ_LOAD_ROW, 3'd1, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd9);
    send_req(REQ_LOAD_ROW, 3'd2, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    // largest single request, granted
    send_req(REQ_REQUEST, 3'd2, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    // request beyond need
    send_req(REQ_REQUEST, 3'd7, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    // request within need but beyond availability
    send_req(REQ_LOAD_AVAIL, 3'd5, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    send_req(REQ_REQUEST, 3'd2, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0);
    // clear rows, then build a state the safety check must refuse
    send_req(REQ_LOAD_ROW, 3'd7, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_req(REQ_LOAD_ROW, 3'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_req(REQ_LOAD_AVAIL, 3'd0, 8'd2, 8'd2, 8'd2, 8'd0, 8'd0, 8'd0);
    send_req(REQ_LOAD_ROW, 3'd3, 8'd1, 8'd1, 8'd1, 8'd4, 8'd4, 8'd4);
    send_req(REQ_LOAD_ROW, 3'd4, 8'd1, 8'd1, 8'd1, 8'd4, 8'd4, 8'd4);
    send_req(REQ_REQUEST, 3'd3, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0);
    // zero request in an already unsafe state
    send_req(REQ_REQUEST, 3'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    // need is tested before availability, resource by resource
    send_req(REQ_LOAD_AVAIL, 3'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    send_req(REQ_REQUEST, 3'd3, 8'd3, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0);
    send_req(REQ_REQUEST, 3'd3, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0);
    // enough units for everyone: safe grant
    send_req(REQ_LOAD_AVAIL, 3'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    send_req(REQ_REQUEST, 3'd4, 8'd3, 8'd3, 8'd3, 8'd0, 8'd0, 8'd0);
    wait_drained();

    // random part in three idling phases
    random_start = sent_items;
    phase = 0;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      next_phase = (sent_items - random_start) * 3 / RANDOM_ITEMS;
      if (next_phase != phase) begin
        wait_drained();
        phase = next_phase;
        send_idle_pct = (phase == 1) ? 87 : 0;
        take_idle_pct = (phase == 1) ? 37 : 0;
      end
      run_scenario();
      if ($urandom_range(0, 99) < 20) wait_drained();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d request items over three idling phases, %0d results checked",
             sent_items, result_cnt);
    $display("%0d safe grants, %0d unsafe requests rolled back, %0d mismatches",
             grant_cnt, unsafe_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
